/* src/dwarf_cfa_prolog_encoder_macros.svh */
// Assertion macros shared by the encoder RTL.
// Each macro expands to one labelled concurrent assertion clocked on clk, gated by rst.
`ifndef DWARF_CFA_PROLOG_ENCODER_MACROS_SVH
`define DWARF_CFA_PROLOG_ENCODER_MACROS_SVH

// Same-cycle implication.
`define DCFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DCFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/dcfa_pkg.sv */
// Types, constants and byte-assembly functions for the call-frame encoder.
// No dependencies; imported by the top level.
package dcfa_pkg;

  localparam int SeqBytes = 17;
  localparam int SeqWidth = SeqBytes * 8;

  localparam logic [31:0] FRAME_RESET  = 32'd8;
  localparam logic [31:0] PUSH_SIZE    = 32'd8;
  localparam logic [7:0]  VEC_REG_BASE = 8'd17;

  localparam logic [7:0] OP_DEF_CFA_OFFSET = 8'h0e;
  localparam logic [7:0] OP_OFFSET         = 8'h80;
  localparam logic [1:0] OP_ADVANCE_SHORT  = 2'b01;
  localparam logic [7:0] OP_ADVANCE1       = 8'h02;
  localparam logic [7:0] OP_ADVANCE2       = 8'h03;
  localparam logic [7:0] OP_ADVANCE4       = 8'h04;

  typedef enum logic [1:0] {
    ACT_PUSH   = 2'd0,
    ACT_ADJUST = 2'd1,
    ACT_VECTOR = 2'd2,
    ACT_BEGIN  = 2'd3
  } action_t;

  // Up to five bytes, least significant byte first.
  typedef struct packed {
    logic [39:0] bytes;
    logic [2:0]  len;
  } piece_t;

  typedef struct packed {
    logic [SeqWidth-1:0] bytes;
    logic [4:0]          len;
  } seq_t;

  function automatic piece_t uleb_piece(logic [31:0] v);
    piece_t p;
    logic [2:0] n;
    if (v[31:7] == '0) begin
      n = 3'd1;
    end else if (v[31:14] == '0) begin
      n = 3'd2;
    end else if (v[31:21] == '0) begin
      n = 3'd3;
    end else if (v[31:28] == '0) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    p.len   = n;
    p.bytes = {4'b0, v[31:28],
               n > 3'd4, v[27:21],
               n > 3'd3, v[20:14],
               n > 3'd2, v[13:7],
               n > 3'd1, v[6:0]};
    return p;
  endfunction

  function automatic piece_t advance_piece(logic [31:0] d);
    piece_t p;
    if (d[31:6] == '0) begin
      p.bytes = {32'b0, OP_ADVANCE_SHORT, d[5:0]};
      p.len   = 3'd1;
    end else if (d[31:8] == '0) begin
      p.bytes = {24'b0, d[7:0], OP_ADVANCE1};
      p.len   = 3'd2;
    end else if (d[31:16] == '0) begin
      p.bytes = {16'b0, d[15:0], OP_ADVANCE2};
      p.len   = 3'd3;
    end else begin
      p.bytes = {d, OP_ADVANCE4};
      p.len   = 3'd5;
    end
    return p;
  endfunction

  function automatic seq_t append(seq_t s, piece_t p);
    seq_t r;
    r.bytes = s.bytes | (SeqWidth'(p.bytes) << {s.len, 3'b000});
    r.len   = s.len + 5'(p.len);
    return r;
  endfunction

  function automatic piece_t byte_piece(logic [7:0] b);
    piece_t p;
    p.bytes = {32'b0, b};
    p.len   = 3'd1;
    return p;
  endfunction

endpackage

/* src/dcfa_in_if.sv */
// Input channel: one prolog unwind event per transfer.
// Depends on nothing beyond the language; valid/ready handshake.
interface dcfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] code_offset;
  logic [3:0]  reg_num;
  logic [31:0] adjust_amount;
  logic [31:0] slot_offset;

  modport source (output valid, action, code_offset, reg_num, adjust_amount, slot_offset,
                  input ready);
  modport sink (input valid, action, code_offset, reg_num, adjust_amount, slot_offset,
                output ready);
endinterface

/* src/dcfa_out_if.sv */
// Output channel: one call-frame instruction byte per transfer.
// Depends on nothing beyond the language; valid/ready handshake.
interface dcfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

/* src/dwarf_cfa_prolog_encoder.sv */
// Top level of the call-frame instruction encoder for prolog unwind events.
// Uses dcfa_pkg, the dcfa_in_if / dcfa_out_if channels and the assertion macros.
//
// Usage: each transfer on in_ch is one prolog event (push, stack adjust, vector
// save or begin). The encoder answers on out_ch with the bytes of the matching
// call-frame instructions, one byte per transfer, with last_byte set on the
// final byte of the event. A begin event restores the frame offset to 8 and the
// previous code offset to 0 and produces no bytes.
// An accepted event is held in an input register, then the whole byte
// sequence (3 to 17 bytes) is built in one pass into a result buffer. The
// first byte is valid once the event has been loaded into the buffer. The
// buffer drains one byte per cycle while the receiver is ready; the next
// event is loaded in the cycle the final byte is taken, giving gap-free
// output. Begin events leave the input register without waiting for the
// buffer. If the receiver stalls, the buffer holds and the input register
// still takes one further event. Reset empties both stages and restores the
// tracked state.
`include "dwarf_cfa_prolog_encoder_macros.svh"

module dwarf_cfa_prolog_encoder
  import dcfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dcfa_in_if.sink   in_ch,
  dcfa_out_if.source out_ch
);

  // Input register.
  logic        stage_valid;
  action_t     stage_action;
  logic [31:0] stage_code;
  logic [3:0]  stage_reg;
  logic [31:0] stage_adj;
  logic [31:0] stage_slot;

  // Tracked unwind state.
  logic [31:0] frame_offset;
  logic [31:0] prev_code_offset;

  // Result buffer: bytes still to send, lowest byte first.
  logic [SeqWidth-1:0] bytes;
  logic [4:0]          remaining;

  logic        in_fire;
  logic        out_fire;
  logic        out_done;
  logic        buf_free;
  logic        stage_move;
  logic        load;
  logic [31:0] frame_offset_next;
  logic [31:0] operand;
  piece_t      operand_piece;
  seq_t        seq;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign out_done   = out_fire && (remaining == 5'd1);
  assign buf_free   = (remaining == 5'd0) || out_done;
  assign stage_move = stage_valid && ((stage_action == ACT_BEGIN) || buf_free);
  assign load       = stage_move && (stage_action != ACT_BEGIN);

  assign in_ch.ready      = !stage_valid || stage_move;
  assign out_ch.valid     = (remaining != 5'd0);
  assign out_ch.out_byte  = bytes[7:0];
  assign out_ch.last_byte = (remaining == 5'd1);

  always_comb begin
    case (stage_action)
      ACT_PUSH:   frame_offset_next = frame_offset + PUSH_SIZE;
      ACT_ADJUST: frame_offset_next = frame_offset + stage_adj;
      default:    frame_offset_next = frame_offset;
    endcase
  end

  // The vector save reports its slot relative to the unchanged frame offset.
  assign operand       = (stage_action == ACT_VECTOR) ? frame_offset - stage_slot
                                                      : frame_offset_next;
  assign operand_piece = uleb_piece(operand);

  always_comb begin
    seq = '0;
    seq = append(seq, advance_piece(stage_code - prev_code_offset));
    case (stage_action)
      ACT_PUSH: begin
        seq = append(seq, byte_piece(OP_DEF_CFA_OFFSET));
        seq = append(seq, operand_piece);
        seq = append(seq, byte_piece(OP_OFFSET | {4'b0, stage_reg}));
        seq = append(seq, operand_piece);
      end
      ACT_ADJUST: begin
        seq = append(seq, byte_piece(OP_DEF_CFA_OFFSET));
        seq = append(seq, operand_piece);
      end
      default: begin
        seq = append(seq, byte_piece(OP_OFFSET | (VEC_REG_BASE + {4'b0, stage_reg})));
        seq = append(seq, operand_piece);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_fire) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_action <= action_t'(in_ch.action);
      stage_code   <= in_ch.code_offset;
      stage_reg    <= in_ch.reg_num;
      stage_adj    <= in_ch.adjust_amount;
      stage_slot   <= in_ch.slot_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset     <= FRAME_RESET;
      prev_code_offset <= 32'd0;
    end else if (stage_move) begin
      if (stage_action == ACT_BEGIN) begin
        frame_offset     <= FRAME_RESET;
        prev_code_offset <= 32'd0;
      end else begin
        frame_offset     <= frame_offset_next;
        prev_code_offset <= stage_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 5'd0;
    end else if (load) begin
      remaining <= seq.len;
    end else if (out_fire) begin
      remaining <= remaining - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= seq.bytes;
    end else if (out_fire) begin
      bytes <= bytes >> 8;
    end
  end

  `DCFA_ASSERT_IMP(a_remaining_bound, out_ch.valid, remaining <= 5'(SeqBytes), "byte count beyond buffer")
  `DCFA_ASSERT_IMP(a_load_when_free, load, (remaining == 5'd0) || out_done, "buffer overwritten while draining")
  `DCFA_ASSERT_NXT(a_drain_empties, out_done && !load, !out_ch.valid, "bytes sent after the final byte")
  `DCFA_ASSERT_NXT(a_begin_resets, stage_move && stage_action == ACT_BEGIN, frame_offset == FRAME_RESET && prev_code_offset == 32'd0, "begin did not restore state")

endmodule
